@@ rtl/epft_pkg.sv @@
// ----------------------------------------------------------------------------
// epft_pkg
// shared constants and codes for the edge pair find-or-add table
// ----------------------------------------------------------------------------
`default_nettype none

package epft_pkg;

    localparam int unsigned MAX_EDGES_DEF   = 1024;
    localparam int unsigned VERTEX_BITS_DEF = 12;

    // width of the edge_index result field
    localparam int unsigned EDGE_INDEX_W = 10;

    localparam logic KIND_FIND_OR_ADD = 1'b0;
    localparam logic KIND_FIND_ONLY   = 1'b1;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_ADDED     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

endpackage : epft_pkg

`default_nettype wire

@@ rtl/edge_pair_find_or_add_table_unit.sv @@
// ----------------------------------------------------------------------------
// edge_pair_find_or_add_table_unit
// table of unordered vertex pairs with find-or-add and find-only requests
// ----------------------------------------------------------------------------
// a request is taken when start is high and busy is low; kind selects
// find-or-add or find-only, vertex_a / vertex_b give the pair in either order.
// the table lives in one single-port-read ram, one entry (both ends) per word.
// the search walks the valid entries from the newest down to index 0, one ram
// read per cycle, and stops at the first match, which is the highest index.
// after acceptance a request walks the ram reads, compares each entry from the
// registered ram output and then registers the result, which drives the result
// strobe; a hit ends the walk early. busy stays high until the result is
// registered, so one request is handled at a time. a miss on find-or-add
// appends the pair in the final scan cycle.
// the result sits on edge_index / status for exactly one cycle with done high;
// the receiver cannot stall it. reset empties the table (entry count to zero);
// ram contents are not cleared, entries at or above the count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_pair_find_or_add_table_unit
    import epft_pkg::*;
#(
    parameter int unsigned MAX_EDGES   = MAX_EDGES_DEF,
    parameter int unsigned VERTEX_BITS = VERTEX_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    kind,
    input  wire logic [VERTEX_BITS-1:0]  vertex_a,
    input  wire logic [VERTEX_BITS-1:0]  vertex_b,
    output logic                         done,
    output logic [EDGE_INDEX_W-1:0]      edge_index,
    output logic [1:0]                   status
);

    localparam int unsigned IW = $clog2(MAX_EDGES);
    localparam int unsigned CW = $clog2(MAX_EDGES + 1);
    localparam int unsigned DW = 2 * VERTEX_BITS;
    localparam int unsigned XW = IW + EDGE_INDEX_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [IW-1:0]           addr_reg, addr_next;
    logic                    more_reg, more_next;
    logic                    cmp_valid_reg, cmp_valid_next;
    logic [IW-1:0]           cmp_idx_reg, cmp_idx_next;
    logic                    kind_reg, kind_next;
    logic [VERTEX_BITS-1:0]  va_reg, va_next;
    logic [VERTEX_BITS-1:0]  vb_reg, vb_next;
    logic                    done_reg, done_next;
    logic [IW-1:0]           res_idx_reg, res_idx_next;
    status_t                 res_status_reg, res_status_next;

    logic                    rd_en;
    logic [DW-1:0]           rd_data;
    logic                    wr_en;
    logic [IW-1:0]           wr_addr;
    logic [VERTEX_BITS-1:0]  end0, end1;
    logic                    hit;
    logic                    full;
    logic [XW-1:0]           idx_wide;

    epft_pair_ram #(
        .DEPTH  (MAX_EDGES),
        .DATA_W (DW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({vb_reg, va_reg}),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    assign end0 = rd_data[VERTEX_BITS-1:0];
    assign end1 = rd_data[DW-1:VERTEX_BITS];
    assign hit  = cmp_valid_reg &&
                  (((end0 == va_reg) && (end1 == vb_reg)) ||
                   ((end0 == vb_reg) && (end1 == va_reg)));
    assign full = (count_reg == CW'(MAX_EDGES));

    assign rd_en   = (state_reg == S_SCAN) && more_reg;
    // append only once all reads are done, so no read and write of one entry overlap
    assign wr_en   = (state_reg == S_SCAN) && !more_reg && !hit &&
                     (kind_reg == KIND_FIND_OR_ADD) && !full;
    assign wr_addr = count_reg[IW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        addr_next       = addr_reg;
        more_next       = more_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        kind_next       = kind_reg;
        va_next         = va_reg;
        vb_next         = vb_reg;
        done_next       = 1'b0;
        res_idx_next    = res_idx_reg;
        res_status_next = res_status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next  = kind;
                    va_next    = vertex_a;
                    vb_next    = vertex_b;
                    // newest entry first
                    addr_next  = IW'(count_reg - CW'(1));
                    more_next  = (count_reg != '0);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (more_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = addr_reg;
                    addr_next      = addr_reg - IW'(1);
                    more_next      = (addr_reg != '0);
                end
                if (hit)
                begin
                    done_next       = 1'b1;
                    res_idx_next    = cmp_idx_reg;
                    res_status_next = ST_FOUND;
                    cmp_valid_next  = 1'b0;
                    more_next       = 1'b0;
                    state_next      = S_IDLE;
                end
                else if (!more_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (kind_reg == KIND_FIND_ONLY)
                    begin
                        res_idx_next    = '0;
                        res_status_next = ST_NOT_FOUND;
                    end
                    else if (full)
                    begin
                        res_idx_next    = '0;
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        res_idx_next    = count_reg[IW-1:0];
                        res_status_next = ST_ADDED;
                        count_next      = count_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            more_reg      <= 1'b0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            more_reg      <= more_next;
            cmp_valid_reg <= cmp_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        cmp_idx_reg    <= cmp_idx_next;
        kind_reg       <= kind_next;
        va_reg         <= va_next;
        vb_reg         <= vb_next;
        res_idx_reg    <= res_idx_next;
        res_status_reg <= res_status_next;
    end

    assign idx_wide   = XW'(res_idx_reg);
    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign edge_index = idx_wide[EDGE_INDEX_W-1:0];
    assign status     = res_status_reg;

    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_SCAN) && (state_reg == S_IDLE))
        else $error("result strobe without a finished scan");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_EDGES))
        else $error("entry count beyond table depth");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (count_reg < CW'(MAX_EDGES)) && !rd_en)
        else $error("append into a full table or during a read");

    a_count_only_on_add: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> done_reg && (res_status_reg == ST_ADDED))
        else $error("entry count moved without an append result");

endmodule : edge_pair_find_or_add_table_unit

`default_nettype wire

@@ rtl/epft_pair_ram.sv @@
// ----------------------------------------------------------------------------
// epft_pair_ram
// edge store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module epft_pair_ram
    import epft_pkg::*;
#(
    parameter int unsigned DEPTH  = MAX_EDGES_DEF,
    parameter int unsigned DATA_W = 2 * VERTEX_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [DATA_W-1:0]          wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [DATA_W-1:0]          rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : epft_pair_ram

`default_nettype wire

@@ tb/edge_pair_find_or_add_table_unit_tb.sv @@
// ----------------------------------------------------------------------------
// edge_pair_find_or_add_table_unit_tb
// self-checking bench for the edge pair find-or-add table
// ----------------------------------------------------------------------------
// requests are queued by a sequencing block and presented by a clocked
// driver with random idle bursts. each accepted request is resolved against
// a local copy of the edge table, and the expected edge_index / status are
// compared with every done strobe. the run covers an empty table, both
// request kinds, either vertex order, extreme vertex values and random
// traffic, and ends with back-to-back requests and no idling.
// ----------------------------------------------------------------------------
module edge_pair_find_or_add_table_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import epft_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int TABLE_SIZE  = MAX_EDGES_DEF;
    localparam int BATCH_LEN   = 20;

    typedef logic [VERTEX_BITS_DEF-1:0] vertex_t;

    typedef struct packed {
        logic    kind;
        vertex_t a;
        vertex_t b;
    } pair_request_t;

    typedef struct packed {
        logic [EDGE_INDEX_W-1:0] slot;
        status_t                 code;
    } edge_result_t;

    logic    clk      = 1'b0;
    logic    rst_n    = 1'b0;
    logic    start    = 1'b0;
    logic    kind     = KIND_FIND_OR_ADD;
    vertex_t vertex_a = '0;
    vertex_t vertex_b = '0;

    logic                    busy;
    logic                    done;
    logic [EDGE_INDEX_W-1:0] edge_index;
    logic [1:0]              status;

    // local copy of the edge table
    vertex_t stored_a [TABLE_SIZE];
    vertex_t stored_b [TABLE_SIZE];
    int      stored_count = 0;

    pair_request_t pending_requests [$];
    pair_request_t batch [$];
    edge_result_t  expected_results [$];

    int pushed_cnt   = 0;
    int resolved_cnt = 0;
    int failures     = 0;
    int cycle_count  = 0;
    int gap_percent  = 0;
    int gap_left     = 0;

    edge_pair_find_or_add_table_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .vertex_a   (vertex_a),
        .vertex_b   (vertex_b),
        .done       (done),
        .edge_index (edge_index),
        .status     (status)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // highest stored index holding the unordered pair, or -1
    function automatic int find_pair(vertex_t a, vertex_t b);
        for (int i = stored_count - 1; i >= 0; i--)
        begin
            if ((stored_a[i] == a && stored_b[i] == b) ||
                (stored_a[i] == b && stored_b[i] == a))
                return i;
        end
        return -1;
    endfunction

    function automatic edge_result_t resolve_request(logic k, vertex_t a, vertex_t b);
        edge_result_t r;
        int           hit;
        hit    = find_pair(a, b);
        r.slot = '0;
        if (hit >= 0)
        begin
            r.slot = EDGE_INDEX_W'(hit);
            r.code = ST_FOUND;
        end
        else if (k == KIND_FIND_ONLY)
            r.code = ST_NOT_FOUND;
        else if (stored_count >= TABLE_SIZE)
            r.code = ST_FULL;
        else
        begin
            stored_a[stored_count] = a;
            stored_b[stored_count] = b;
            r.slot = EDGE_INDEX_W'(stored_count);
            r.code = ST_ADDED;
            stored_count++;
        end
        return r;
    endfunction

    function automatic vertex_t rand_vertex();
        int pick;
        pick = $urandom_range(15);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        else if (pick < 4)
            return vertex_t'($urandom_range(7));
        else
            return vertex_t'($urandom);
    endfunction

    function automatic bit pair_known(vertex_t a, vertex_t b);
        if (find_pair(a, b) >= 0)
            return 1'b1;
        foreach (batch[i])
        begin
            if ((batch[i].a == a && batch[i].b == b) ||
                (batch[i].a == b && batch[i].b == a))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic add_to_batch(logic k, vertex_t a, vertex_t b);
        pair_request_t r;
        r.kind = k;
        r.a    = a;
        r.b    = b;
        batch = {batch, r};
    endtask

    task automatic pick_fresh(output vertex_t a, output vertex_t b);
        do
        begin
            a = rand_vertex();
            b = rand_vertex();
        end
        while (pair_known(a, b));
    endtask

    // a stored pair, in either order
    task automatic pick_stored(output vertex_t a, output vertex_t b);
        int idx;
        idx = $urandom_range(stored_count - 1);
        if ($urandom_range(1) == 0)
        begin
            a = stored_a[idx];
            b = stored_b[idx];
        end
        else
        begin
            a = stored_b[idx];
            b = stored_a[idx];
        end
    endtask

    // hand the batch to the driver and wait for all its results
    task automatic run_batch();
        pending_requests = {pending_requests, batch};
        pushed_cnt += batch.size();
        batch.delete();
        while (resolved_cnt < pushed_cnt)
            @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        edge_result_t  outcome;
        pair_request_t next_req;
        logic          free;
        if (!rst_n)
        begin
            start    <= 1'b0;
            kind     <= KIND_FIND_OR_ADD;
            vertex_a <= '0;
            vertex_b <= '0;
            gap_left = 0;
        end
        else
        begin
            free = !start;
            if (start && !busy)
            begin
                outcome = resolve_request(kind, vertex_a, vertex_b);
                expected_results = {expected_results, outcome};
                free = 1'b1;
            end
            if (free)
            begin
                if (gap_left > 0 && gap_percent > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (gap_percent > 0 && $urandom_range(99) < gap_percent)
                begin
                    // start an idle burst, this cycle included; gap_left holds the idle cycles still to come
                    gap_left = $urandom_range(14);
                    start <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    next_req = pending_requests.pop_front();
                    start    <= 1'b1;
                    kind     <= next_req.kind;
                    vertex_a <= next_req.a;
                    vertex_b <= next_req.b;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        edge_result_t want;
        if (rst_n && done)
        begin
            resolved_cnt++;
            if (expected_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: edge_index=%0d status=%0d",
                             edge_index, status);
            end
            else
            begin
                want = expected_results.pop_front();
                if (edge_index !== want.slot || status !== want.code)
                begin
                    failures++;
                    if (failures <= 10)
                        $display({"mismatch: expected edge_index=%0d status=%s, ",
                                  "got edge_index=%0d status=%0d"},
                                 want.slot, want.code.name(), edge_index, status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : sequencer
        vertex_t a;
        vertex_t b;
        int      roll;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, either order, self loops
        gap_percent = 20;
        add_to_batch(KIND_FIND_ONLY,   12'h000, 12'h000);
        add_to_batch(KIND_FIND_OR_ADD, 12'h000, 12'h000);
        add_to_batch(KIND_FIND_OR_ADD, 12'hFFF, 12'hFFF);
        add_to_batch(KIND_FIND_OR_ADD, 12'h000, 12'hFFF);
        add_to_batch(KIND_FIND_OR_ADD, 12'hFFF, 12'h000);
        add_to_batch(KIND_FIND_ONLY,   12'hFFF, 12'h000);
        add_to_batch(KIND_FIND_ONLY,   12'h000, 12'h000);
        add_to_batch(KIND_FIND_ONLY,   12'h001, 12'h002);
        add_to_batch(KIND_FIND_OR_ADD, 12'hAAA, 12'h555);
        add_to_batch(KIND_FIND_OR_ADD, 12'h555, 12'hAAA);
        add_to_batch(KIND_FIND_ONLY,   12'hAAA, 12'hAAA);
        add_to_batch(KIND_FIND_ONLY,   12'h555, 12'h555);
        add_to_batch(KIND_FIND_OR_ADD, 12'h800, 12'h001);
        add_to_batch(KIND_FIND_ONLY,   12'h001, 12'h800);
        add_to_batch(KIND_FIND_OR_ADD, 12'h7FF, 12'h800);
        add_to_batch(KIND_FIND_OR_ADD, 12'h123, 12'h123);
        add_to_batch(KIND_FIND_ONLY,   12'h000, 12'hFFF);
        add_to_batch(KIND_FIND_OR_ADD, 12'hFFF, 12'hFFF);
        add_to_batch(KIND_FIND_ONLY,   12'hFFE, 12'hFFF);
        add_to_batch(KIND_FIND_OR_ADD, 12'h000, 12'h000);
        run_batch();

        // random traffic, the last batches with no idling
        for (int c = 0; c < 28; c++)
        begin
            if (c >= 24)
                gap_percent = 0;
            else
            begin
                case ($urandom_range(2))
                    0:       gap_percent = 0;
                    1:       gap_percent = 15;
                    default: gap_percent = 50;
                endcase
            end
            for (int j = 0; j < BATCH_LEN; j++)
            begin
                roll = $urandom_range(99);
                if (roll < 35 || stored_count == 0)
                begin
                    pick_fresh(a, b);
                    add_to_batch(KIND_FIND_OR_ADD, a, b);
                end
                else if (roll < 60)
                begin
                    pick_stored(a, b);
                    add_to_batch(KIND_FIND_OR_ADD, a, b);
                end
                else if (roll < 80)
                begin
                    pick_stored(a, b);
                    add_to_batch(KIND_FIND_ONLY, a, b);
                end
                else
                    add_to_batch(logic'($urandom_range(1)), rand_vertex(), rand_vertex());
            end
            run_batch();
        end

        // newest entry in either order, stored pairs, a miss and a fresh append
        gap_percent = 0;
        add_to_batch(KIND_FIND_OR_ADD, stored_b[stored_count - 1], stored_a[stored_count - 1]);
        add_to_batch(KIND_FIND_ONLY,   stored_a[stored_count - 1], stored_b[stored_count - 1]);
        add_to_batch(KIND_FIND_ONLY,   12'h000, 12'h000);
        add_to_batch(KIND_FIND_OR_ADD, 12'hFFF, 12'h000);
        for (int j = 0; j < 4; j++)
        begin
            pick_stored(a, b);
            add_to_batch(logic'($urandom_range(1)), a, b);
        end
        pick_fresh(a, b);
        add_to_batch(KIND_FIND_ONLY, a, b);
        add_to_batch(KIND_FIND_OR_ADD, a, b);
        run_batch();

        repeat (20) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            failures++;
            $display("%0d expected results never arrived", expected_results.size());
        end

        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
